### design/nmul_pkg.sv
// Shared constants, types and helpers for the normalizing unsigned multiply.
// Used by nmul_mult, nmul_norm and normalizing_unsigned_multiply.
`timescale 1ns / 1ps
`default_nettype none

package nmul_pkg;

  // Operand and product widths
  localparam int unsigned WIDTH   = 32;
  localparam int unsigned PROD_W  = 2 * WIDTH;
  localparam int unsigned SHIFT_W = $clog2(PROD_W + 1);

  typedef logic [WIDTH-1:0]   word_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [SHIFT_W-1:0] shift_t;

  // Operand beat held in the input register
  typedef struct packed {
    word_t operand_a;
    word_t operand_b;
    word_t scale_in;
    logic  flags_update;
  } opnd_t;

  // Product beat held in the product register
  typedef struct packed {
    word_t product_high;
    word_t product_low;
    word_t scale_in;
    logic  flags_update;
  } prod_beat_t;

  // Leading-zero count of the full product; an all-zero word gives PROD_W
  function automatic shift_t lead_zeros(input prod_t v);
    shift_t n;
    n = shift_t'(PROD_W);
    for (int i = 0; i < PROD_W; i++) begin
      if (v[i]) begin
        n = shift_t'(PROD_W - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### design/nmul_mult.sv
// Multiply stage: forms the full product of the held operands and registers it.
// Depends on nmul_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmul_mult
  import nmul_pkg::*;
(
  input  wire logic       clk_i,
  input  wire opnd_t      opnd_i,
  input  wire logic       load_i,
  output      prod_beat_t prod_o
);

  prod_t      product;
  prod_beat_t prod_d;
  prod_beat_t prod_q;

  // Full-width unsigned product
  assign product = prod_t'(opnd_i.operand_a) * prod_t'(opnd_i.operand_b);

  always_comb begin
    prod_d.product_high = product[PROD_W-1:WIDTH];
    prod_d.product_low  = product[WIDTH-1:0];
    prod_d.scale_in     = opnd_i.scale_in;
    prod_d.flags_update = opnd_i.flags_update;
  end

  // Hold the product until the next stage takes it
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### design/nmul_norm.sv
// Normalize stage: leading-zero count, normalizing shift, scale update, flags.
// Registers the result beat. Depends on nmul_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmul_norm
  import nmul_pkg::*;
(
  input  wire logic       clk_i,
  input  wire prod_beat_t prod_i,
  input  wire logic       load_i,
  output      word_t      product_high_o,
  output      word_t      product_low_o,
  output      word_t      normalized_o,
  output      word_t      scale_out_o,
  output      logic       flags_written_o,
  output      logic       zero_flag_o,
  output      logic       nonzero_flag_o
);

  prod_t  full;
  prod_t  shifted;
  shift_t lz;
  word_t  norm_d,  norm_q;
  word_t  scale_d, scale_q;
  word_t  high_q,  low_q;
  logic   upd_q;
  logic   zero_d,  zero_q;
  logic   nzero_d, nzero_q;

  // Shift the leading one to the top; a zero product shifts out entirely
  always_comb begin
    full    = {prod_i.product_high, prod_i.product_low};
    lz      = lead_zeros(full);
    shifted = full << lz;
    norm_d  = shifted[PROD_W-1:WIDTH];
    scale_d = prod_i.scale_in + word_t'(lz) - word_t'(WIDTH);
    zero_d  = prod_i.flags_update & (norm_d == '0);
    nzero_d = prod_i.flags_update & (norm_d != '0);
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      high_q  <= prod_i.product_high;
      low_q   <= prod_i.product_low;
      norm_q  <= norm_d;
      scale_q <= scale_d;
      upd_q   <= prod_i.flags_update;
      zero_q  <= zero_d;
      nzero_q <= nzero_d;
    end
  end

  assign product_high_o  = high_q;
  assign product_low_o   = low_q;
  assign normalized_o    = norm_q;
  assign scale_out_o     = scale_q;
  assign flags_written_o = upd_q;
  assign zero_flag_o     = zero_q;
  assign nonzero_flag_o  = nzero_q;

endmodule

`default_nettype wire

### design/normalizing_unsigned_multiply.sv
// Top level of the normalizing unsigned multiply: input register and beat flow.
// Depends on nmul_pkg, nmul_mult and nmul_norm.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one operand beat per cycle while in_stall_o is low and returns one
// result beat per beat, in order. A beat passes three registers (input,
// product, result); the result register drives the outputs. The multiplier
// and the normalizing shifter each sit between a pair of these registers.
// Stalls propagate back through the stages, and each stage refills in the
// cycle it empties, so full rate is kept under any stall pattern that lets
// results drain.
module normalizing_unsigned_multiply
  import nmul_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output      logic  in_stall_o,
  input  wire word_t operand_a_i,
  input  wire word_t operand_b_i,
  input  wire word_t scale_in_i,
  input  wire logic  flags_update_i,
  output      logic  out_valid_o,
  input  wire logic  out_stall_i,
  output      word_t product_high_o,
  output      word_t product_low_o,
  output      word_t normalized_o,
  output      word_t scale_out_o,
  output      logic  flags_written_o,
  output      logic  zero_flag_o,
  output      logic  nonzero_flag_o
);

  logic       opnd_vld_q, prod_vld_q, res_vld_q;
  logic       opnd_en, prod_en, res_en;
  opnd_t      opnd_q;
  prod_beat_t prod_beat;

  // A stage loads when it is empty or its beat moves on
  assign res_en     = !res_vld_q  || !out_stall_i;
  assign prod_en    = !prod_vld_q || res_en;
  assign opnd_en    = !opnd_vld_q || prod_en;
  assign in_stall_o = !opnd_en;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opnd_vld_q <= 1'b0;
      prod_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (opnd_en) begin
        opnd_vld_q <= in_valid_i;
      end
      if (prod_en) begin
        prod_vld_q <= opnd_vld_q;
      end
      if (res_en) begin
        res_vld_q <= prod_vld_q;
      end
    end
  end

  // Capture the operand beat
  always_ff @(posedge clk_i) begin
    if (opnd_en) begin
      opnd_q.operand_a    <= operand_a_i;
      opnd_q.operand_b    <= operand_b_i;
      opnd_q.scale_in     <= scale_in_i;
      opnd_q.flags_update <= flags_update_i;
    end
  end

  nmul_mult u_mult (
    .clk_i  (clk_i),
    .opnd_i (opnd_q),
    .load_i (prod_en),
    .prod_o (prod_beat)
  );

  nmul_norm u_norm (
    .clk_i           (clk_i),
    .prod_i          (prod_beat),
    .load_i          (res_en),
    .product_high_o  (product_high_o),
    .product_low_o   (product_low_o),
    .normalized_o    (normalized_o),
    .scale_out_o     (scale_out_o),
    .flags_written_o (flags_written_o),
    .zero_flag_o     (zero_flag_o),
    .nonzero_flag_o  (nonzero_flag_o)
  );

  assign out_valid_o = res_vld_q;

endmodule

`default_nettype wire
